FILE: design/wavrh_pkg.sv
// ----------------------------------------------------------------------------
// wavrh_pkg
// shared types and constants of the riff/wave header parser
// ----------------------------------------------------------------------------
`default_nettype none

package wavrh_pkg;

   // chunk and file tags, first character in the top byte
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;

   localparam logic [31:0] MIN_FILE  = 32'd44;
   localparam logic [31:0] FMT_MIN   = 32'd16;
   localparam logic [32:0] FILE_HDR  = 33'd12;
   localparam logic [33:0] CHUNK_HDR = 34'd8;
   localparam logic [15:0] PCM_CODE  = 16'd1;
   localparam logic [32:0] OFFSET_MAX = 33'h1_FFFF_FFFF;

   // walk phases
   localparam logic [2:0] PH_FILE    = 3'd0;
   localparam logic [2:0] PH_HDR     = 3'd1;
   localparam logic [2:0] PH_PAYLOAD = 3'd2;
   localparam logic [2:0] PH_PAD     = 3'd3;
   localparam logic [2:0] PH_DONE    = 3'd4;

   // result status codes
   localparam logic [2:0] ST_OK         = 3'd0;
   localparam logic [2:0] ST_BAD_HEADER = 3'd1;
   localparam logic [2:0] ST_BAD_CHUNK  = 3'd2;
   localparam logic [2:0] ST_NOT_PCM    = 3'd3;
   localparam logic [2:0] ST_MISSING    = 3'd4;

   typedef struct packed {
      logic [2:0]  status;
      logic [15:0] channel_count;
      logic [31:0] rate_hz;
      logic [15:0] sample_bits;
      logic [31:0] pcm_offset;
      logic [31:0] pcm_length;
   } res_type;

endpackage

`default_nettype wire

FILE: design/wav_riff_header_parser_core.sv
// ----------------------------------------------------------------------------
// wav_riff_header_parser_core
// byte-stream riff/wave header parser with one status word per file
// ----------------------------------------------------------------------------
// The block takes one file byte per cycle while req_tready is high, and returns
// one result word for the byte marked tlast, after that byte has passed the
// input register and then the result register. The only stall comes from the
// single result register: a last byte waits in the input register while a
// previous result has not been taken, which holds req_tready low.
`default_nettype none

module wav_riff_header_parser_core (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   input  wire  [39:0]  req_tdata,   // data_byte[7:0], file_size[39:8]
   input  wire          req_tlast,   // is_last
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   output logic [127:0] rsp_tdata,   // channel_count[15:0], rate_hz[47:16],
                                     // sample_bits[63:48], pcm_offset[95:64],
                                     // pcm_length[127:96]
   output logic [2:0]   rsp_tuser    // status[2:0]
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic [31:0]        in_size_ff;
   logic               in_last_ff;
   logic               out_free;
   logic               step;
   logic               res_valid;
   wavrh_pkg::res_type res;

   // a word without tlast never needs the result register
   assign step       = in_valid_ff && (!in_last_ff || out_free);
   assign req_tready = !in_valid_ff || step;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata[7:0];
         in_size_ff <= req_tdata[39:8];
         in_last_ff <= req_tlast;
      end
   end

   wavrh_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .item_valid (step),
      .data_byte  (in_byte_ff),
      .file_size  (in_size_ff),
      .is_last    (in_last_ff),
      .res_valid  (res_valid),
      .res        (res)
   );

   wavrh_out u_out (
      .clock      (clock),
      .reset      (reset),
      .load       (res_valid),
      .res        (res),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

`default_nettype wire

FILE: design/wavrh_parse.sv
// ----------------------------------------------------------------------------
// wavrh_parse
// walk state and per-byte update; produces the result on the last byte
// ----------------------------------------------------------------------------
`default_nettype none

module wavrh_parse (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    item_valid,
   input  wire [7:0]              data_byte,
   input  wire [31:0]             file_size,
   input  wire                    is_last,
   output logic                   res_valid,
   output wavrh_pkg::res_type     res
);

   logic [32:0] off_ff, off_in;
   logic [31:0] size_ff, size_in;
   logic [2:0]  phase_ff, phase_in;
   logic [31:0] tag_ff, tag_in;
   logic [31:0] len_ff, len_in;
   logic [32:0] pend_ff, pend_in;
   logic [15:0] ftag_ff, ftag_in;
   logic [63:0] fields_ff, fields_in;
   logic [63:0] dloc_ff, dloc_in;
   logic [1:0]  seen_ff, seen_in;
   logic [2:0]  err_ff, err_in;
   logic [4:0]  pos_ff, pos_in;

   logic [2:0]  cur_phase;
   logic        pos_restart;
   logic [31:0] len_new;
   logic [31:0] tag_new;
   logic [15:0] ftag_new;
   logic [33:0] hdr_endp;
   logic [33:0] hdr_next0;
   logic [33:0] pay_next;
   logic [33:0] pad_next;
   logic        pay_last;
   logic [2:0]  status;

   assign len_new   = {data_byte, len_ff[23:0]};
   assign tag_new   = {tag_ff[23:0], data_byte};
   assign ftag_new  = {data_byte, ftag_ff[7:0]};
   assign hdr_endp  = {1'b0, pend_ff} + {2'b00, len_new};
   assign hdr_next0 = {1'b0, pend_ff} + wavrh_pkg::CHUNK_HDR;
   assign pay_next  = {1'b0, pend_ff} + {33'd0, len_ff[0]} + wavrh_pkg::CHUNK_HDR;
   assign pad_next  = {1'b0, off_ff} + 34'd1 + wavrh_pkg::CHUNK_HDR;
   assign pay_last  = ({1'b0, off_ff} + 34'd1) == {1'b0, pend_ff};

   always_comb begin
      off_in      = off_ff;
      size_in     = size_ff;
      phase_in    = phase_ff;
      tag_in      = tag_ff;
      len_in      = len_ff;
      pend_in     = pend_ff;
      ftag_in     = ftag_ff;
      fields_in   = fields_ff;
      dloc_in     = dloc_ff;
      seen_in     = seen_ff;
      err_in      = err_ff;
      pos_in      = pos_ff;
      cur_phase   = phase_ff;
      pos_restart = 1'b0;
      status      = wavrh_pkg::ST_OK;
      res_valid   = 1'b0;
      res         = '0;

      if (item_valid) begin
         if (off_ff == 33'd0) begin
            size_in = file_size;
            if (file_size < wavrh_pkg::MIN_FILE) begin
               err_in    = wavrh_pkg::ST_BAD_HEADER;
               cur_phase = wavrh_pkg::PH_DONE;
               phase_in  = wavrh_pkg::PH_DONE;
            end
         end

         case (cur_phase)
            wavrh_pkg::PH_FILE: begin
               if (off_ff < 33'd4 || (off_ff >= 33'd8 && off_ff < wavrh_pkg::FILE_HDR)) begin
                  tag_in = tag_new;
               end
               if (off_ff == 33'd3 && tag_new != wavrh_pkg::TAG_RIFF) begin
                  err_in   = wavrh_pkg::ST_BAD_HEADER;
                  phase_in = wavrh_pkg::PH_DONE;
               end else if (off_ff == wavrh_pkg::FILE_HDR - 33'd1) begin
                  if (tag_new != wavrh_pkg::TAG_WAVE) begin
                     err_in   = wavrh_pkg::ST_BAD_HEADER;
                     phase_in = wavrh_pkg::PH_DONE;
                  end else if (34'd20 > {2'b00, size_in}) begin
                     phase_in = wavrh_pkg::PH_DONE;
                  end else begin
                     phase_in    = wavrh_pkg::PH_HDR;
                     pend_in     = 33'd20;
                     pos_restart = 1'b1;
                  end
               end
            end
            wavrh_pkg::PH_HDR: begin
               if (pos_ff < 5'd4) begin
                  tag_in = tag_new;
                  len_in = '0;
               end else begin
                  case (pos_ff[1:0])
                     2'd0:    len_in = {len_ff[31:8], data_byte};
                     2'd1:    len_in = {len_ff[31:16], data_byte, len_ff[7:0]};
                     2'd2:    len_in = {len_ff[31:24], data_byte, len_ff[15:0]};
                     default: len_in = len_new;
                  endcase
               end
               // last header byte: check the payload against the file size and the fmt length
               if (pos_ff == 5'd7) begin
                  if (hdr_endp > {2'b00, size_in} ||
                      (tag_ff == wavrh_pkg::TAG_FMT && len_new < wavrh_pkg::FMT_MIN)) begin
                     if (err_in == wavrh_pkg::ST_OK) begin
                        err_in = wavrh_pkg::ST_BAD_CHUNK;
                     end
                     phase_in = wavrh_pkg::PH_DONE;
                  end else begin
                     if (tag_ff == wavrh_pkg::TAG_DATA) begin
                        dloc_in    = {len_new, pend_ff[31:0]};
                        seen_in[1] = 1'b1;
                     end
                     pend_in     = hdr_endp[32:0];
                     pos_restart = 1'b1;
                     if (len_new != 32'd0) begin
                        phase_in = wavrh_pkg::PH_PAYLOAD;
                     end else if (hdr_next0 > {2'b00, size_in}) begin
                        phase_in = wavrh_pkg::PH_DONE;
                     end else begin
                        phase_in = wavrh_pkg::PH_HDR;
                        pend_in  = hdr_next0[32:0];
                     end
                  end
               end
            end
            wavrh_pkg::PH_PAYLOAD: begin
               if (tag_ff == wavrh_pkg::TAG_FMT && pos_ff == 5'd1 &&
                   ftag_new != wavrh_pkg::PCM_CODE) begin
                  ftag_in = ftag_new;
                  if (err_in == wavrh_pkg::ST_OK) begin
                     err_in = wavrh_pkg::ST_NOT_PCM;
                  end
                  phase_in = wavrh_pkg::PH_DONE;
               end else begin
                  if (tag_ff == wavrh_pkg::TAG_FMT) begin
                     case (pos_ff)
                        5'd0:    ftag_in = {8'd0, data_byte};
                        5'd1:    ftag_in = ftag_new;
                        5'd2:    fields_in[7:0]   = data_byte;
                        5'd3:    fields_in[15:8]  = data_byte;
                        5'd4:    fields_in[23:16] = data_byte;
                        5'd5:    fields_in[31:24] = data_byte;
                        5'd6:    fields_in[39:32] = data_byte;
                        5'd7:    fields_in[47:40] = data_byte;
                        5'd14:   fields_in[55:48] = data_byte;
                        5'd15: begin
                           fields_in[63:56] = data_byte;
                           seen_in[0]       = 1'b1;
                        end
                        default: ;
                     endcase
                  end
                  if (pay_last) begin
                     pos_restart = 1'b1;
                     if (pay_next > {2'b00, size_in}) begin
                        phase_in = wavrh_pkg::PH_DONE;
                     end else if (len_ff[0]) begin
                        phase_in = wavrh_pkg::PH_PAD;
                     end else begin
                        phase_in = wavrh_pkg::PH_HDR;
                        pend_in  = pay_next[32:0];
                     end
                  end
               end
            end
            wavrh_pkg::PH_PAD: begin
               pos_restart = 1'b1;
               if (pad_next > {2'b00, size_in}) begin
                  phase_in = wavrh_pkg::PH_DONE;
               end else begin
                  phase_in = wavrh_pkg::PH_HDR;
                  pend_in  = pad_next[32:0];
               end
            end
            default: ;
         endcase

         if (pos_restart) begin
            pos_in = '0;
         end else if (pos_ff != 5'd31) begin
            pos_in = pos_ff + 5'd1;
         end

         if (off_ff < wavrh_pkg::OFFSET_MAX) begin
            off_in = off_ff + 33'd1;
         end

         if (is_last) begin
            if (err_in != wavrh_pkg::ST_OK) begin
               status = err_in;
            end else if (phase_in == wavrh_pkg::PH_FILE) begin
               status = wavrh_pkg::ST_BAD_HEADER;
            end else if (phase_in != wavrh_pkg::PH_DONE) begin
               status = wavrh_pkg::ST_BAD_CHUNK;
            end else if (seen_in != 2'b11 || dloc_in[63:32] == 32'd0) begin
               status = wavrh_pkg::ST_MISSING;
            end else begin
               status = wavrh_pkg::ST_OK;
            end
            res_valid  = 1'b1;
            res.status = status;
            if (status == wavrh_pkg::ST_OK) begin
               res.channel_count = fields_in[15:0];
               res.rate_hz       = fields_in[47:16];
               res.sample_bits   = fields_in[63:48];
               res.pcm_offset    = dloc_in[31:0];
               res.pcm_length    = dloc_in[63:32];
            end
            // restart for the next file
            off_in    = '0;
            size_in   = '0;
            phase_in  = wavrh_pkg::PH_FILE;
            tag_in    = '0;
            len_in    = '0;
            pend_in   = '0;
            ftag_in   = '0;
            fields_in = '0;
            dloc_in   = '0;
            seen_in   = '0;
            err_in    = wavrh_pkg::ST_OK;
            pos_in    = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         off_ff    <= '0;
         size_ff   <= '0;
         phase_ff  <= wavrh_pkg::PH_FILE;
         tag_ff    <= '0;
         len_ff    <= '0;
         pend_ff   <= '0;
         ftag_ff   <= '0;
         fields_ff <= '0;
         dloc_ff   <= '0;
         seen_ff   <= '0;
         err_ff    <= wavrh_pkg::ST_OK;
         pos_ff    <= '0;
      end else begin
         off_ff    <= off_in;
         size_ff   <= size_in;
         phase_ff  <= phase_in;
         tag_ff    <= tag_in;
         len_ff    <= len_in;
         pend_ff   <= pend_in;
         ftag_ff   <= ftag_in;
         fields_ff <= fields_in;
         dloc_ff   <= dloc_in;
         seen_ff   <= seen_in;
         err_ff    <= err_in;
         pos_ff    <= pos_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/wavrh_out.sv
// ----------------------------------------------------------------------------
// wavrh_out
// result register of the parser, holds one word until the sink takes it
// ----------------------------------------------------------------------------
`default_nettype none

module wavrh_out (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    load,
   input  wire wavrh_pkg::res_type res,
   output logic                   free,
   output logic                   rsp_tvalid,
   input  wire                    rsp_tready,
   output logic [127:0]           rsp_tdata,
   output logic [2:0]             rsp_tuser
);

   logic               valid_ff, valid_in;
   wavrh_pkg::res_type res_ff;

   assign free = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= res;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = res_ff.status;
   assign rsp_tdata  = {res_ff.pcm_length, res_ff.pcm_offset, res_ff.sample_bits,
                        res_ff.rate_hz, res_ff.channel_count};

endmodule

`default_nettype wire

FILE: design/wavrh_chk.sv
// ----------------------------------------------------------------------------
// wavrh_chk
// port-level checks of the header parser, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module wavrh_chk (
   input wire         clock,
   input wire         reset,
   input wire         rsp_tvalid,
   input wire         rsp_tready,
   input wire [127:0] rsp_tdata,
   input wire [2:0]   rsp_tuser
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result word changed while stalled");

   // no result right after reset
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // status stays within the defined codes
   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser <= wavrh_pkg::ST_MISSING)
      else $error("undefined status code");

   // fields are cleared on any error status
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != wavrh_pkg::ST_OK |-> rsp_tdata == '0)
      else $error("fields not cleared on error");

   // an ok file always has a non-empty data chunk
   a_ok_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == wavrh_pkg::ST_OK |-> rsp_tdata[127:96] != 32'd0)
      else $error("ok status with empty data chunk");

endmodule

bind wav_riff_header_parser_core wavrh_chk u_chk (.*);

`default_nettype wire
